// ===== design/csg_pkg.sv =====
// Package for the cosine similarity block: widths, controller states, datapath
// commands, the control and status structs, and small magnitude helpers.
// No dependencies.
package csg_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned DEPTH = 1 << IDX_W;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 7;

  localparam logic [CNT_W-1:0] STEP_LAST_MUL = 7'd47;
  localparam logic [CNT_W-1:0] STEP_LAST_DIV = 7'd95;

  localparam logic CFG_PROP_X = 1'b0;
  localparam logic CFG_PROP_Y = 1'b1;

  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_PMUL,
    S_RINIT,
    S_ROOT,
    S_SINIT,
    S_GPROD,
    S_GSUM,
    S_GNUM,
    S_DMUL,
    S_DINIT,
    S_DIV,
    S_ROUND,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_FETCH,
    CMD_CHECK,
    CMD_MSTEP,
    CMD_RINIT,
    CMD_RSTEP,
    CMD_SINIT,
    CMD_GPROD,
    CMD_GSUM,
    CMD_GNUM,
    CMD_DINIT,
    CMD_VSTEP,
    CMD_ROUND,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic zero_norm;
    logic out_free;
    logic kind;
    logic side;
  } stat_t;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

endpackage

// ===== design/csg_ctrl.sv =====
// Controller state machine of the cosine similarity block.
// Sequences the datapath by commands; depends on csg_pkg.
module csg_ctrl
  import csg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  operation_i,
  input  logic  last_element_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic in_acc;

  assign in_acc = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_BACKWARD) begin
            state_d = S_FETCH;
          end else if (last_element_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_FETCH: state_d = S_CHECK;
      S_CHECK: state_d = stat_i.zero_norm ? S_OUT : S_PMUL;
      S_PMUL: begin
        if (cnt_q == STEP_LAST_MUL) begin
          state_d = S_RINIT;
        end
      end
      S_RINIT: state_d = S_ROOT;
      S_ROOT: begin
        if (cnt_q == STEP_LAST_MUL) begin
          state_d = (stat_i.kind == OP_FORWARD) ? S_SINIT : S_GPROD;
        end
      end
      S_SINIT: state_d = S_DIV;
      S_GPROD: state_d = S_GSUM;
      S_GSUM:  state_d = S_GNUM;
      S_GNUM:  state_d = S_DMUL;
      S_DMUL: begin
        if (cnt_q == STEP_LAST_MUL) begin
          state_d = S_DINIT;
        end
      end
      S_DINIT: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == STEP_LAST_DIV) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (stat_i.kind == OP_BACKWARD && !stat_i.side) begin
          state_d = S_GPROD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd  = CMD_NONE;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:  ctl_o.cmd = in_acc ? CMD_ACCEPT : CMD_NONE;
      S_FETCH: ctl_o.cmd = CMD_FETCH;
      S_CHECK: ctl_o.cmd = CMD_CHECK;
      S_PMUL:  ctl_o.cmd = CMD_MSTEP;
      S_RINIT: ctl_o.cmd = CMD_RINIT;
      S_ROOT:  ctl_o.cmd = CMD_RSTEP;
      S_SINIT: ctl_o.cmd = CMD_SINIT;
      S_GPROD: ctl_o.cmd = CMD_GPROD;
      S_GSUM:  ctl_o.cmd = CMD_GSUM;
      S_GNUM:  ctl_o.cmd = CMD_GNUM;
      S_DMUL:  ctl_o.cmd = CMD_MSTEP;
      S_DINIT: ctl_o.cmd = CMD_DINIT;
      S_DIV:   ctl_o.cmd = CMD_VSTEP;
      S_ROUND: ctl_o.cmd = CMD_ROUND;
      S_OUT:   ctl_o.cmd = stat_i.out_free ? CMD_EMIT : CMD_NONE;
      default: ctl_o.cmd = CMD_NONE;
    endcase
  end

  assign cnt_d = (state_d != state_q) ? '0 : cnt_q + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_bwd_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && operation_i == OP_BACKWARD) |=> state_q == S_FETCH)
    else $error("backward transaction did not start a fetch");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PMUL || state_q == S_DMUL || state_q == S_ROOT) |-> cnt_q <= STEP_LAST_MUL)
    else $error("serial step count overran");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> cnt_q <= STEP_LAST_DIV)
    else $error("division step count overran");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && stat_i.out_free) |=> state_q == S_IDLE)
    else $error("result hand-off did not return to idle");

endmodule

// ===== design/csg_datapath.sv =====
// Datapath of the cosine similarity block: running sums, per-sample stores,
// serial multiplier, square root, divider and the output register. Uses csg_pkg.
module csg_datapath
  import csg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  output stat_t              stat_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic               cfg_data_i,
  input  logic               operation_i,
  input  logic [IDX_W-1:0]   sample_index_i,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic signed [15:0] upstream_grad_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic signed [15:0] similarity_o,
  output logic signed [31:0] grad_x_o,
  output logic signed [31:0] grad_y_o,
  output logic               zero_norm_o
);

  logic prop_x_q, prop_y_q;
  logic [SUM_W-1:0] run_xx_q, run_yy_q, run_xy_q;
  logic [SUM_W-1:0] new_xx, new_yy, new_xy;
  logic signed [31:0] sq_x, sq_y, pr_xy;
  logic store_en, fwd_acc;

  logic [SUM_W-1:0] mem_xx [DEPTH];
  logic [SUM_W-1:0] mem_yy [DEPTH];
  logic [SUM_W-1:0] mem_xy [DEPTH];
  logic [SUM_W-1:0] rd_xx_q, rd_yy_q, rd_xy_q;

  logic [15:0] x_q, y_q, g_q;
  logic kind_q, side_q;
  logic [SUM_W-1:0] xx_q, yy_q, xy_q;

  logic [95:0] mul_acc_q, mul_a_q;
  logic [47:0] mul_b_q;

  logic [95:0] sq_p_q;
  logic [49:0] rem_q;
  logic [47:0] root_q;
  logic [51:0] r4, trial;

  logic [63:0] ga_q, gb_q, mn_q;
  logic sa_q, sb_q, sign_q;
  logic [15:0] own, other, mo, mw, mg;
  logic [47:0] norm, md;
  logic [63:0] prod_a, prod_b;
  logic [79:0] num_p;

  logic [95:0] dvd_q, dvs_q, rmd_q;
  logic [33:0] quo_q;
  logic ovf_q;
  logic [96:0] r2, diff;
  logic ge;
  logic rnd;
  logic [34:0] qf;
  logic [15:0] sat16;
  logic [31:0] sat32;

  logic [15:0] res_sim_q;
  logic [31:0] res_gx_q, res_gy_q;
  logic res_zn_q;

  logic out_valid_q, out_kind_q, out_zn_q;
  logic [15:0] out_sim_q;
  logic [31:0] out_gx_q, out_gy_q;

  assign sq_x  = x_value_i * x_value_i;
  assign sq_y  = y_value_i * y_value_i;
  assign pr_xy = x_value_i * y_value_i;
  assign new_xx = run_xx_q + {16'd0, sq_x};
  assign new_yy = run_yy_q + {16'd0, sq_y};
  assign new_xy = run_xy_q + {{16{pr_xy[31]}}, pr_xy};

  assign fwd_acc  = (ctl_i.cmd == CMD_ACCEPT) && (operation_i == OP_FORWARD);
  assign store_en = fwd_acc && last_element_i;

  assign own   = side_q ? y_q : x_q;
  assign other = side_q ? x_q : y_q;
  assign norm  = side_q ? yy_q : xx_q;
  assign mo    = mag16(other);
  assign mw    = mag16(own);
  assign mg    = mag16(g_q);
  assign md    = mag48(xy_q);
  assign prod_a = mo * norm;
  assign prod_b = md * mw;
  assign num_p  = mn_q * mg;

  assign r4    = {rem_q, sq_p_q[95:94]};
  assign trial = {2'b00, root_q, 2'b01};

  assign r2   = {rmd_q, dvd_q[95]};
  assign diff = r2 - {1'b0, dvs_q};
  assign ge   = (r2 >= {1'b0, dvs_q});

  assign rnd = ({1'b0, rmd_q} << 1) >= {1'b0, dvs_q};
  assign qf  = {1'b0, quo_q} + {34'd0, rnd};

  always_comb begin
    if (!sign_q) begin
      sat16 = (ovf_q || qf > 35'd32767) ? 16'h7FFF : qf[15:0];
      sat32 = (ovf_q || qf > 35'h07FFFFFFF) ? 32'h7FFFFFFF : qf[31:0];
    end else begin
      sat16 = (ovf_q || qf > 35'd32768) ? 16'h8000 : (~qf[15:0] + 16'd1);
      sat32 = (ovf_q || qf > 35'h080000000) ? 32'h80000000 : (~qf[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_xx[sample_index_i] <= new_xx;
      mem_yy[sample_index_i] <= new_yy;
      mem_xy[sample_index_i] <= new_xy;
    end
    if (ctl_i.cmd == CMD_ACCEPT && operation_i == OP_BACKWARD) begin
      rd_xx_q <= mem_xx[sample_index_i];
      rd_yy_q <= mem_yy[sample_index_i];
      rd_xy_q <= mem_xy[sample_index_i];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CMD_ACCEPT: begin
        x_q    <= x_value_i;
        y_q    <= y_value_i;
        g_q    <= upstream_grad_i;
        kind_q <= operation_i;
        if (store_en) begin
          xx_q <= new_xx;
          yy_q <= new_yy;
          xy_q <= new_xy;
        end
      end
      CMD_FETCH: begin
        xx_q <= rd_xx_q;
        yy_q <= rd_yy_q;
        xy_q <= rd_xy_q;
      end
      CMD_CHECK: begin
        res_sim_q <= '0;
        res_gx_q  <= '0;
        res_gy_q  <= '0;
        res_zn_q  <= (xx_q == '0) || (yy_q == '0);
        mul_acc_q <= '0;
        mul_a_q   <= {48'd0, xx_q};
        mul_b_q   <= yy_q;
      end
      CMD_MSTEP: begin
        if (mul_b_q[0]) begin
          mul_acc_q <= mul_acc_q + mul_a_q;
        end
        mul_a_q <= mul_a_q << 1;
        mul_b_q <= mul_b_q >> 1;
      end
      CMD_RINIT: begin
        sq_p_q <= mul_acc_q;
        rem_q  <= '0;
        root_q <= '0;
        side_q <= 1'b0;
      end
      CMD_RSTEP: begin
        if (r4 >= trial) begin
          rem_q  <= 50'(r4 - trial);
          root_q <= {root_q[46:0], 1'b1};
        end else begin
          rem_q  <= r4[49:0];
          root_q <= {root_q[46:0], 1'b0};
        end
        sq_p_q <= sq_p_q << 2;
      end
      CMD_SINIT: begin
        dvd_q  <= {33'd0, md, 15'd0};
        dvs_q  <= {48'd0, root_q};
        rmd_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        sign_q <= xy_q[47];
      end
      CMD_GPROD: begin
        ga_q <= prod_a;
        gb_q <= prod_b;
        sa_q <= other[15];
        sb_q <= ~(xy_q[47] ^ own[15]);
      end
      CMD_GSUM: begin
        if (sa_q == sb_q) begin
          mn_q   <= ga_q + gb_q;
          sign_q <= sa_q ^ g_q[15];
        end else if (ga_q >= gb_q) begin
          mn_q   <= ga_q - gb_q;
          sign_q <= sa_q ^ g_q[15];
        end else begin
          mn_q   <= gb_q - ga_q;
          sign_q <= sb_q ^ g_q[15];
        end
      end
      CMD_GNUM: begin
        dvd_q     <= {num_p, 16'd0};
        mul_acc_q <= '0;
        mul_a_q   <= {48'd0, root_q};
        mul_b_q   <= norm;
      end
      CMD_DINIT: begin
        dvs_q <= mul_acc_q;
        rmd_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
      end
      CMD_VSTEP: begin
        rmd_q <= ge ? diff[95:0] : r2[95:0];
        quo_q <= {quo_q[32:0], ge};
        ovf_q <= ovf_q | quo_q[33];
        dvd_q <= dvd_q << 1;
      end
      CMD_ROUND: begin
        if (kind_q == OP_FORWARD) begin
          res_sim_q <= sat16;
        end else if (!side_q) begin
          res_gx_q <= sat32;
          side_q   <= 1'b1;
        end else begin
          res_gy_q <= sat32;
        end
      end
      CMD_EMIT: begin
        out_kind_q <= kind_q;
        out_sim_q  <= res_sim_q;
        out_gx_q   <= prop_x_q ? res_gx_q : '0;
        out_gy_q   <= prop_y_q ? res_gy_q : '0;
        out_zn_q   <= res_zn_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_x_q    <= 1'b1;
      prop_y_q    <= 1'b1;
      run_xx_q    <= '0;
      run_yy_q    <= '0;
      run_xy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PROP_X: prop_x_q <= cfg_data_i;
          CFG_PROP_Y: prop_y_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (fwd_acc) begin
        if (last_element_i) begin
          run_xx_q <= '0;
          run_yy_q <= '0;
          run_xy_q <= '0;
        end else begin
          run_xx_q <= new_xx;
          run_yy_q <= new_yy;
          run_xy_q <= new_xy;
        end
      end
      if (ctl_i.cmd == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.zero_norm = (xx_q == '0) || (yy_q == '0);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.kind      = kind_q;
  assign stat_o.side      = side_q;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign similarity_o  = out_sim_q;
  assign grad_x_o      = out_gx_q;
  assign grad_y_o      = out_gy_q;
  assign zero_norm_o   = out_zn_q;

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cmd == CMD_EMIT) |=> out_valid_o)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.cmd == CMD_EMIT) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while still held");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_en |=> (run_xx_q == '0 && run_yy_q == '0 && run_xy_q == '0))
    else $error("running sums not cleared after the last element");

endmodule

// ===== design/cosine_similarity_with_gradient.sv =====
// Top level of the cosine similarity block with gradient.
// Joins csg_ctrl and csg_datapath; uses csg_pkg.
// A forward element that is not the last of its vector is taken without leaving idle.
// The last forward element and a backward element are computed serially:
// the 48-step serial multiplier forms xx*yy, a 48-step square root yields d,
// and a 96-step restoring divider produces each rounded quotient (one for the
// similarity, one per gradient, each gradient also needing a 48-step d*norm
// product). A zero-norm sample skips from the check to the output. The next
// transaction is taken while a finished result still waits at the output.
module cosine_similarity_with_gradient
  import csg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [IDX_W-1:0]   sample_index_i,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic signed [15:0] upstream_grad_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic signed [15:0] similarity_o,
  output logic signed [31:0] grad_x_o,
  output logic signed [31:0] grad_y_o,
  output logic               zero_norm_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic               cfg_data_i
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  csg_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .last_element_i (last_element_i),
    .stat_i         (stat),
    .ctl_o          (ctl)
  );

  csg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .sample_index_i  (sample_index_i),
    .x_value_i       (x_value_i),
    .y_value_i       (y_value_i),
    .upstream_grad_i (upstream_grad_i),
    .last_element_i  (last_element_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .similarity_o    (similarity_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .zero_norm_o     (zero_norm_o)
  );

endmodule
